// File: design/deq_pkg.sv
// Shared types and codes for the double-ended queue core.
// No dependencies; imported by every module of the block.
package deq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_READ_FRONT = 3'd4,
		CMD_READ_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 9;

	// Memory port strobes from the pointer logic.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// Per-transaction result info that travels alongside the memory read.
	typedef struct packed {
		status_t            status;
		logic               use_data;
		logic [OCC_W-1:0]   occupancy;
	} info_t;

endpackage

// File: design/deq_ctrl.sv
// Pointer and count logic: decodes the command, updates front/back/count.
// Depends on deq_pkg.
module deq_ctrl #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [2:0]                 command,
	output deq_pkg::mem_ctl_t          mem_ctl,
	output logic [$clog2(DEPTH)-1:0]   addr,
	output deq_pkg::info_t             info
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [AW-1:0] front_q, back_q, front_d, back_d;
	logic [CW-1:0] count_q, count_d;
	logic          empty, full, wr, rd, use_data;
	status_t       status;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - AW'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		wr       = 1'b0;
		rd       = 1'b0;
		use_data = 1'b0;
		status   = ST_OK;
		addr     = front_q;
		unique case (command) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else if (command == CMD_PUSH_FRONT) begin
					front_d = ring_dec(front_q);
					addr    = front_d;
					wr      = 1'b1;
					count_d = count_q + CW'(1);
				end else begin
					addr    = back_q;
					back_d  = ring_inc(back_q);
					wr      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_READ_FRONT, CMD_READ_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					rd       = 1'b1;
					use_data = 1'b1;
					if (command == CMD_POP_FRONT) begin
						addr    = front_q;
						front_d = ring_inc(front_q);
						count_d = count_q - CW'(1);
					end else if (command == CMD_POP_BACK) begin
						back_d  = ring_dec(back_q);
						addr    = back_d;
						count_d = count_q - CW'(1);
					end else if (command == CMD_READ_FRONT) begin
						addr = front_q;
					end else begin
						addr = ring_dec(back_q);
					end
				end
			end
			default: ;
		endcase
	end

	assign mem_ctl.wr_en  = accept & wr;
	assign mem_ctl.rd_en  = accept & rd;
	assign info.status    = status;
	assign info.use_data  = use_data;
	assign info.occupancy = OCC_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

endmodule

// File: design/deq_mem.sv
// Word store: single-port synchronous RAM, one write or one read per cycle.
// Depends on deq_pkg.
module deq_mem #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  deq_pkg::mem_ctl_t          mem_ctl,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [31:0]                wdata,
	output logic [31:0]                rdata
);
	import deq_pkg::*;

	logic [DATA_W-1:0] word_store_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Read data holds until the next read strobe.
	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			word_store_q[addr] <= wdata;
		end
		if (mem_ctl.rd_en) begin
			rd_data_q <= word_store_q[addr];
		end
	end

	assign rdata = rd_data_q;

endmodule

// File: design/double_ended_queue_core.sv
// Top level of the double-ended queue: pointer logic, word store, result pipe.
// Depends on deq_pkg, deq_ctrl and deq_mem.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------
//   in      | in_valid / in_ready | command[2:0], value[31:0]
//   out     | out_valid/out_ready | data[31:0], status[1:0], occupancy[8:0]
//
// One transaction per cycle sustained while the output is not stalled; each goes
// from accept through the store's registered read, then the output register.
// Reset clears the front and back indices and the count; the store itself
// is not cleared and needs no pass after reset.
// A stalled output holds its result; the input keeps accepting while the
// read stage is empty or can drain into the output register.
module double_ended_queue_core #(
	parameter int DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] data,
	output logic [1:0]         status,
	output logic [8:0]         occupancy
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	mem_ctl_t          mem_ctl;
	info_t             info, info_s1;
	logic [AW-1:0]     addr;
	logic [DATA_W-1:0] rdata;
	logic              accept, valid_s1, advance;
	logic              out_valid_q;
	logic [DATA_W-1:0] data_q;
	logic [1:0]        status_q;
	logic [OCC_W-1:0]  occupancy_q;

	// Advance the read stage when the output register is free or draining.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (command),
		.mem_ctl (mem_ctl),
		.addr    (addr),
		.info    (info)
	);

	deq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.addr    (addr),
		.wdata   (value),
		.rdata   (rdata)
	);

	// Read stage: hold the status and occupancy while the store read lands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// Output register: drop store data for pushes and errors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_q      <= info_s1.use_data ? rdata : '0;
			status_q    <= info_s1.status;
			occupancy_q <= info_s1.occupancy;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

endmodule

// File: design/deq_checker.sv
// Port-level checks on the double-ended queue core, bound to the top level.
// Depends on deq_pkg and double_ended_queue_core.
module deq_checker #(
	parameter int DEPTH = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] data,
	input logic [1:0]  status,
	input logic [8:0]  occupancy
);
	import deq_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
		else $error("status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (data == '0))
		else $error("nonzero data on error status");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (occupancy == '0))
		else $error("empty status with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (occupancy == 9'(DEPTH)))
		else $error("full status with occupancy below depth");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(data) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data      (data),
	.status    (status),
	.occupancy (occupancy)
);
